/* hw/rtl/dihedral_pattern_equivalence_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the dihedral pattern equivalence block
// Each macro checks a property on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DIHEDRAL_PATTERN_EQUIVALENCE_DEFINES_SVH
`define DIHEDRAL_PATTERN_EQUIVALENCE_DEFINES_SVH

`ifndef ASSERT_OFF
`define DPE_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dpe assertion failed");
`define DPE_ASSERT_DLY(label, ante, dly, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error("dpe latency assertion failed");
`else
`define DPE_ASSERT(label, ante, cons)
`define DPE_ASSERT_DLY(label, ante, dly, cons)
`endif

`endif

/* hw/rtl/dpe_pkg.sv */
// ----------------------------------------------------------------------------
// Dihedral pattern equivalence package
// Widths and defaults shared by the modules of the block.
// ----------------------------------------------------------------------------
package dpe_pkg;

	localparam int PAT_W = 32;
	localparam int CFG_W = 6;
	localparam int MAX_LEN_DEFAULT = 32;
	localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(32);

endpackage

/* hw/rtl/dpe_prep.sv */
// ----------------------------------------------------------------------------
// Pattern preparation stages
// Masks both patterns to the length, forms the doubled second pattern and
// the doubled mirror of the second pattern over three register stages.
// ----------------------------------------------------------------------------
module dpe_prep #(
	parameter int MAX_LEN = dpe_pkg::MAX_LEN_DEFAULT,
	parameter int LEN_W = $clog2(MAX_LEN + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [dpe_pkg::PAT_W-1:0]   first_pattern,
	input  logic [dpe_pkg::PAT_W-1:0]   second_pattern,
	input  logic [LEN_W-1:0]            len,
	output logic                        valid_s3,
	output logic [MAX_LEN-1:0]          a_s3,
	output logic [MAX_LEN-1:0]          mask_s3,
	output logic [2*MAX_LEN-1:0]        rot_s3,
	output logic [2*MAX_LEN-1:0]        ref_s3
);

	logic [MAX_LEN-1:0] a_ext;
	logic [MAX_LEN-1:0] b_ext;
	logic [MAX_LEN-1:0] mask;

	logic               valid_s1;
	logic [MAX_LEN-1:0] a_s1;
	logic [MAX_LEN-1:0] b_s1;
	logic [MAX_LEN-1:0] mask_s1;
	logic [LEN_W-1:0]   len_s1;

	logic [MAX_LEN-1:0]   b_rev;
	logic [MAX_LEN-1:0]   g_next;
	logic [2*MAX_LEN-1:0] rot_next;

	logic                 valid_s2;
	logic [MAX_LEN-1:0]   a_s2;
	logic [MAX_LEN-1:0]   mask_s2;
	logic [LEN_W-1:0]     len_s2;
	logic [MAX_LEN-1:0]   g_s2;
	logic [2*MAX_LEN-1:0] rot_s2;

	logic [MAX_LEN-1:0]   c_next;
	logic [2*MAX_LEN-1:0] ref_next;

	for (genvar i = 0; i < MAX_LEN; i++) begin : g_ext
		if (i < dpe_pkg::PAT_W) begin : g_in
			assign a_ext[i] = first_pattern[i];
			assign b_ext[i] = second_pattern[i];
		end else begin : g_zero
			assign a_ext[i] = 1'b0;
			assign b_ext[i] = 1'b0;
		end
		assign mask[i] = (LEN_W'(i) < len);
		assign b_rev[i] = b_s1[MAX_LEN-1-i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= a_ext & mask;
		b_s1    <= b_ext & mask;
		mask_s1 <= mask;
		len_s1  <= len;
	end

	// Reversed pattern aligned so that bit j holds position n-1-j.
	assign g_next   = b_rev >> (LEN_W'(MAX_LEN) - len_s1);
	assign rot_next = {{MAX_LEN{1'b0}}, b_s1} | ({{MAX_LEN{1'b0}}, b_s1} << len_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		a_s2    <= a_s1;
		mask_s2 <= mask_s1;
		len_s2  <= len_s1;
		g_s2    <= g_next;
		rot_s2  <= rot_next;
	end

	// Mirror image: bit 0 holds position 0 and bit j holds position n-j.
	assign c_next   = ((g_s2 << 1) & mask_s2) | {{(MAX_LEN-1){1'b0}}, rot_s2[0]};
	assign ref_next = {{MAX_LEN{1'b0}}, c_next} | ({{MAX_LEN{1'b0}}, c_next} << len_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		a_s3    <= a_s2;
		mask_s3 <= mask_s2;
		rot_s3  <= rot_s2;
		ref_s3  <= ref_next;
	end

endmodule

/* hw/rtl/dpe_match.sv */
// ----------------------------------------------------------------------------
// Symmetry compare and reduce stages
// Compares the first pattern against every rotation and reflection window
// and reduces the hits to one flag over two register stages.
// ----------------------------------------------------------------------------
module dpe_match #(
	parameter int MAX_LEN = dpe_pkg::MAX_LEN_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s3,
	input  logic [MAX_LEN-1:0]   a_s3,
	input  logic [MAX_LEN-1:0]   mask_s3,
	input  logic [2*MAX_LEN-1:0] rot_s3,
	input  logic [2*MAX_LEN-1:0] ref_s3,
	output logic                 valid_s5,
	output logic                 equivalent_s5
);

	logic [MAX_LEN-1:0] hit;
	logic               valid_s4;
	logic [MAX_LEN-1:0] hit_s4;

	for (genvar s = 0; s < MAX_LEN; s++) begin : g_shift
		logic rot_hit;
		logic ref_hit;
		assign rot_hit = ~|((rot_s3[s +: MAX_LEN] ^ a_s3) & mask_s3);
		assign ref_hit = ~|((ref_s3[s +: MAX_LEN] ^ a_s3) & mask_s3);
		assign hit[s]  = mask_s3[s] & (rot_hit | ref_hit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		hit_s4        <= hit;
		equivalent_s5 <= |hit_s4;
	end

endmodule

/* hw/rtl/dihedral_pattern_equivalence.sv */
// ----------------------------------------------------------------------------
// Dihedral pattern equivalence check
// An accepted item passes the registers s1 to s5, and done is high while its
// verdict is shown on equivalent.
// Throughput: one item per cycle through five pipeline stages; busy stays low.
// Reset: arst_n clears all valid bits and sets the pattern length to 32.
// The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
`include "dihedral_pattern_equivalence_defines.svh"

module dihedral_pattern_equivalence #(
	parameter int MAX_LEN = dpe_pkg::MAX_LEN_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [dpe_pkg::CFG_W-1:0]   cfg_wr_data,
	input  logic                        start,
	output logic                        busy,
	input  logic [dpe_pkg::PAT_W-1:0]   first_pattern,
	input  logic [dpe_pkg::PAT_W-1:0]   second_pattern,
	output logic                        done,
	output logic                        equivalent
);

	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int LAT = 5;
	localparam logic [dpe_pkg::CFG_W:0] MAX_CFG = (dpe_pkg::CFG_W + 1)'(MAX_LEN);

	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     len_next;
	logic                 valid_s3;
	logic [MAX_LEN-1:0]   a_s3;
	logic [MAX_LEN-1:0]   mask_s3;
	logic [2*MAX_LEN-1:0] rot_s3;
	logic [2*MAX_LEN-1:0] ref_s3;

	// A length of zero acts as one and lengths above the maximum saturate.
	always_comb begin
		if (cfg_wr_data == '0) begin
			len_next = LEN_W'(1);
		end else if ({1'b0, cfg_wr_data} > MAX_CFG) begin
			len_next = LEN_W'(MAX_LEN);
		end else begin
			len_next = LEN_W'(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= (({1'b0, dpe_pkg::LEN_RESET}) > MAX_CFG) ? LEN_W'(MAX_LEN)
				: LEN_W'(dpe_pkg::LEN_RESET);
		end else if (cfg_wr_en) begin
			len_q <= len_next;
		end
	end

	assign busy = 1'b0;

	dpe_prep #(
		.MAX_LEN (MAX_LEN),
		.LEN_W   (LEN_W)
	) u_prep (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (start & ~busy),
		.first_pattern  (first_pattern),
		.second_pattern (second_pattern),
		.len            (len_q),
		.valid_s3       (valid_s3),
		.a_s3           (a_s3),
		.mask_s3        (mask_s3),
		.rot_s3         (rot_s3),
		.ref_s3         (ref_s3)
	);

	dpe_match #(
		.MAX_LEN (MAX_LEN)
	) u_match (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s3      (valid_s3),
		.a_s3          (a_s3),
		.mask_s3       (mask_s3),
		.rot_s3        (rot_s3),
		.ref_s3        (ref_s3),
		.valid_s5      (done),
		.equivalent_s5 (equivalent)
	);

	`DPE_ASSERT_DLY(a_start_done, start && !busy, LAT, done)
	`DPE_ASSERT(a_done_from_start, done, $past(start && !busy, LAT))
	`DPE_ASSERT(a_identity_match, done && $past(first_pattern == second_pattern, LAT), equivalent)

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the dihedral pattern equivalence check
// A short table of pattern pairs covers the extremes, the ignored upper bits,
// a zero length and lengths past the maximum. Random pairs follow in phases,
// each under its own length and idling mode. Most pairs are true rotations
// or reflections of one another. Every verdict is compared with the table's
// verdict where given, else with a local model of the group action.
// ----------------------------------------------------------------------------
module tb;

	typedef struct {
		logic [dpe_pkg::CFG_W-1:0] len;
		logic [dpe_pkg::PAT_W-1:0] first;
		logic [dpe_pkg::PAT_W-1:0] second;
		bit                        known;
		bit                        eq;
	} stim_row_t;

	typedef struct {
		logic [dpe_pkg::PAT_W-1:0] first;
		logic [dpe_pkg::PAT_W-1:0] second;
		bit                        eq;
	} verdict_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_wr_en;
	logic [dpe_pkg::CFG_W-1:0] cfg_wr_data;
	logic                      start;
	logic                      busy;
	logic [dpe_pkg::PAT_W-1:0] first_pattern;
	logic [dpe_pkg::PAT_W-1:0] second_pattern;
	logic                      done;
	logic                      equivalent;

	verdict_t                  awaited_verdicts[$];
	verdict_t                  head_verdict;
	logic [dpe_pkg::CFG_W-1:0] cur_len = dpe_pkg::LEN_RESET;
	int unsigned               gap_pct = 0;
	int unsigned               n_errors = 0;
	int unsigned               n_items = 0;
	int unsigned               n_matched = 0;
	int unsigned               n_results = 0;
	int unsigned               n_lengths = 0;

	stim_row_t directed_rows [0:22] = '{
		'{6'd32, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1},
		'{6'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1},
		'{6'd32, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0},
		'{6'd32, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0},
		'{6'd32, 32'h0000_0001, 32'h8000_0000, 1'b1, 1'b1},
		'{6'd32, 32'h1234_5678, 32'h1234_5678, 1'b1, 1'b1},
		'{6'd32, 32'h0000_0001, 32'h0000_0003, 1'b1, 1'b0},
		'{6'd32, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b1},
		'{6'd32, 32'h0000_000B, 32'h0000_000D, 1'b0, 1'b0},
		'{6'd32, 32'h0000_000B, 32'hB000_0000, 1'b0, 1'b0},
		'{6'd32, 32'h8000_0001, 32'h0000_0003, 1'b1, 1'b1},
		'{6'd0,  32'h0000_0001, 32'h0000_0001, 1'b1, 1'b1},
		'{6'd0,  32'hFFFF_FFFE, 32'h0000_0001, 1'b1, 1'b0},
		'{6'd0,  32'hFFFF_FFFE, 32'h0000_0000, 1'b1, 1'b1},
		'{6'd1,  32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 1'b1},
		'{6'd4,  32'h0000_00F0, 32'h0000_0000, 1'b1, 1'b1},
		'{6'd4,  32'h0000_0001, 32'h0000_0008, 1'b1, 1'b1},
		'{6'd4,  32'h0000_0003, 32'h0000_0005, 1'b1, 1'b0},
		'{6'd63, 32'h0000_0001, 32'h8000_0000, 1'b1, 1'b1},
		'{6'd63, 32'h0000_FFFF, 32'hFFFF_0000, 1'b1, 1'b1},
		'{6'd33, 32'h0000_0001, 32'h0000_0002, 1'b1, 1'b1},
		'{6'd2,  32'h0000_0001, 32'h0000_0002, 1'b1, 1'b1},
		'{6'd5,  32'h0000_000B, 32'h0000_001A, 1'b0, 1'b0}
	};

	dihedral_pattern_equivalence i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.start         (start),
		.busy          (busy),
		.first_pattern (first_pattern),
		.second_pattern(second_pattern),
		.done          (done),
		.equivalent    (equivalent)
	);

	always #5 clk = ~clk;

	function automatic int unsigned positions_used(input logic [dpe_pkg::CFG_W-1:0] len);
		int unsigned n;
		n = (len == 0) ? 1 : len;
		if (n > dpe_pkg::MAX_LEN_DEFAULT) n = dpe_pkg::MAX_LEN_DEFAULT;
		return n;
	endfunction

	function automatic bit dihedral_equal(input logic [dpe_pkg::CFG_W-1:0] len,
			input logic [dpe_pkg::PAT_W-1:0] a, input logic [dpe_pkg::PAT_W-1:0] b);
		int unsigned n;
		int unsigned t;
		bit rot_ok;
		bit ref_ok;
		n = positions_used(len);
		for (int unsigned s = 0; s < n; s++) begin
			rot_ok = 1'b1;
			ref_ok = 1'b1;
			for (int unsigned j = 0; j < n; j++) begin
				t = (j + s) % n;
				if (a[j] != b[t]) rot_ok = 1'b0;
				if (a[j] != b[(n - t) % n]) ref_ok = 1'b0;
			end
			if (rot_ok || ref_ok) return 1'b1;
		end
		return 1'b0;
	endfunction

	// Moves position j of a to its image under the chosen symmetry; positions
	// past the length are filled from upper.
	function automatic logic [dpe_pkg::PAT_W-1:0] dihedral_image(
			input logic [dpe_pkg::CFG_W-1:0] len,
			input logic [dpe_pkg::PAT_W-1:0] a, input int unsigned s, input bit mirror,
			input logic [dpe_pkg::PAT_W-1:0] upper);
		int unsigned n;
		int unsigned t;
		logic [dpe_pkg::PAT_W-1:0] mask;
		logic [dpe_pkg::PAT_W-1:0] img;
		n = positions_used(len);
		mask = (n >= dpe_pkg::PAT_W) ? '1
			: ((dpe_pkg::PAT_W'(1) << n) - dpe_pkg::PAT_W'(1));
		img = upper & ~mask;
		for (int unsigned j = 0; j < n; j++) begin
			t = (j + s) % n;
			img[mirror ? (n - t) % n : t] = a[j];
		end
		return img;
	endfunction

	task automatic report_mismatch(input string msg);
		n_errors++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic send_item(input logic [dpe_pkg::PAT_W-1:0] a,
			input logic [dpe_pkg::PAT_W-1:0] b, input bit known, input bit eq);
		verdict_t v;
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		first_pattern <= a;
		second_pattern <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		v.first = a;
		v.second = b;
		v.eq = known ? eq : dihedral_equal(cur_len, a, b);
		awaited_verdicts.push_back(v);
		n_items++;
	endtask

	task automatic drain;
		start <= 1'b0;
		while (awaited_verdicts.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_length(input logic [dpe_pkg::CFG_W-1:0] len);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= len;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_len = len;
		n_lengths++;
	endtask

	task automatic send_random_pair;
		logic [dpe_pkg::PAT_W-1:0] a;
		logic [dpe_pkg::PAT_W-1:0] b;
		int unsigned n;
		n = positions_used(cur_len);
		case ($urandom_range(3))
			0: a = $urandom & $urandom & $urandom;
			1: a = $urandom | $urandom | $urandom;
			default: a = $urandom;
		endcase
		b = dihedral_image(cur_len, a, $urandom_range(n - 1), $urandom_range(1), $urandom);
		case ($urandom_range(9))
			5: b[$urandom_range(n - 1)] ^= 1'b1;
			6: b = a;
			7: b = $urandom;
			8: b = $urandom & $urandom & $urandom;
			9: begin
				a = {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
				b = $urandom_range(1) ? a : ~a;
			end
			default: ;
		endcase
		send_item(a, b, 1'b0, 1'b0);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			n_results++;
			if (awaited_verdicts.size() == 0) begin
				report_mismatch($sformatf("verdict %0b with no item outstanding", equivalent));
			end else begin
				head_verdict = awaited_verdicts.pop_front();
				if (equivalent !== head_verdict.eq)
					report_mismatch($sformatf("%08h vs %08h: equivalent %b, expected %0b",
						head_verdict.first, head_verdict.second, equivalent, head_verdict.eq));
				if (head_verdict.eq) n_matched++;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d verdicts outstanding", awaited_verdicts.size());
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [dpe_pkg::CFG_W-1:0] phase_lengths [0:11];
		phase_lengths = '{6'd32, 6'd1, 6'd0, 6'd2, 6'd3, 6'd5, 6'd8, 6'd17,
			6'd31, 6'd33, 6'd63, 6'($urandom_range(63))};
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		start <= 1'b0;
		first_pattern <= '0;
		second_pattern <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(directed_rows); i++) begin
			if (directed_rows[i].len != cur_len) begin
				drain();
				set_length(directed_rows[i].len);
			end
			send_item(directed_rows[i].first, directed_rows[i].second,
				directed_rows[i].known, directed_rows[i].eq);
		end

		for (int p = 0; p < $size(phase_lengths); p++) begin
			drain();
			set_length(phase_lengths[p]);
			case (p % 3)
				0: gap_pct = 0;
				1: gap_pct = 60;
				default: gap_pct = 8;
			endcase
			repeat (111) send_random_pair();
		end

		drain();
		gap_pct = 0;
		if (awaited_verdicts.size() != 0)
			report_mismatch($sformatf("%0d verdicts never arrived", awaited_verdicts.size()));
		$display("%0d pattern pairs under %0d length writes, zero and saturated lengths included",
			n_items, n_lengths);
		$display("%0d verdicts checked, %0d of them equivalent", n_results, n_matched);
		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
